// File: sv/bmo_pkg.sv
// Shared types, sizes and codes for the buy/sell order matcher.
package bmo_pkg;

  // Table size and derived widths.
  localparam int TableDepth = 128;
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int GroupSize  = 8;
  localparam int NumGroups  = (TableDepth + GroupSize - 1) / GroupSize;

  // Field widths fixed by the interface.
  localparam int CatW     = 16;
  localparam int PriceW   = 16;
  localparam int OutcomeW = 2;

  // Side codes.
  localparam logic SIDE_WANTED  = 1'b0;
  localparam logic SIDE_FORSALE = 1'b1;

  // Outcome codes.
  localparam logic [OutcomeW-1:0] OUTCOME_STORED  = 2'd0;
  localparam logic [OutcomeW-1:0] OUTCOME_TRADED  = 2'd1;
  localparam logic [OutcomeW-1:0] OUTCOME_DROPPED = 2'd2;

  // One offer beat; a stored table entry has the same layout.
  typedef struct packed {
    logic [CatW-1:0]   item_category;
    logic              offer_side;
    logic [PriceW-1:0] offer_price;
  } offer_t;

  // One result beat.
  typedef struct packed {
    logic [OutcomeW-1:0] outcome;
    logic [PriceW-1:0]   trade_price;
  } result_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic cmp;
    logic load;
    logic shift;
  } cell_ctl_t;

  // Priority unit stage enables.
  typedef struct packed {
    logic grp;
    logic sel;
  } prio_ctl_t;

endpackage

// File: sv/bmo_cell.sv
// One table cell: holds an entry, compares it to the offer, shifts down on removal.
module bmo_cell (
  input  logic               clk,
  input  bmo_pkg::cell_ctl_t ctl,
  input  logic               live,
  input  bmo_pkg::offer_t    offer,
  input  bmo_pkg::offer_t    nbr,
  output bmo_pkg::offer_t    entry,
  output logic               hit
);

  logic hit_now;
  logic price_ok;

  // A sale offer needs a wanted price at or above it; a wanted offer the reverse.
  always_comb begin
    if (offer.offer_side == bmo_pkg::SIDE_FORSALE) begin
      price_ok = offer.offer_price <= entry.offer_price;
    end else begin
      price_ok = offer.offer_price >= entry.offer_price;
    end
    hit_now = live && (entry.item_category == offer.item_category) &&
              (entry.offer_side != offer.offer_side) && price_ok;
  end

  // Entry storage: append loads the offer, removal pulls from the next cell up.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= offer;
    end else if (ctl.shift) begin
      entry <= nbr;
    end
  end

  // Registered match flag.
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit <= hit_now;
    end
  end

endmodule

// File: sv/bmo_prio.sv
// Two-stage priority unit: picks the oldest matching cell and the shift mask.
module bmo_prio (
  input  logic                             clk,
  input  bmo_pkg::prio_ctl_t               ctl,
  input  logic [bmo_pkg::TableDepth-1:0]   hit,
  output logic [bmo_pkg::TableDepth-1:0]   sel,
  output logic [bmo_pkg::TableDepth-1:0]   shift,
  output logic                             found
);

  logic [bmo_pkg::NumGroups-1:0]  grp_any;
  logic [bmo_pkg::NumGroups-1:0]  grp_any_next;
  logic [bmo_pkg::TableDepth-1:0] sel_next;
  logic [bmo_pkg::TableDepth-1:0] shift_next;

  // First stage: one OR per group of cells.
  always_comb begin
    grp_any_next = '0;
    for (int g = 0; g < bmo_pkg::NumGroups; g++) begin
      for (int k = 0; k < bmo_pkg::GroupSize; k++) begin
        if (g * bmo_pkg::GroupSize + k < bmo_pkg::TableDepth) begin
          grp_any_next[g] = grp_any_next[g] | hit[g * bmo_pkg::GroupSize + k];
        end
      end
    end
  end

  // Second stage: prefix over groups, then within each group.
  always_comb begin
    logic earlier;
    logic inner_excl;
    logic inner_incl;
    sel_next   = '0;
    shift_next = '0;
    earlier    = 1'b0;
    for (int g = 0; g < bmo_pkg::NumGroups; g++) begin
      inner_excl = 1'b0;
      inner_incl = 1'b0;
      for (int k = 0; k < bmo_pkg::GroupSize; k++) begin
        if (g * bmo_pkg::GroupSize + k < bmo_pkg::TableDepth) begin
          inner_incl = inner_excl | hit[g * bmo_pkg::GroupSize + k];
          sel_next[g * bmo_pkg::GroupSize + k] =
            hit[g * bmo_pkg::GroupSize + k] & ~earlier & ~inner_excl;
          shift_next[g * bmo_pkg::GroupSize + k] = earlier | inner_incl;
          inner_excl = inner_incl;
        end
      end
      earlier = earlier | grp_any[g];
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (ctl.grp) begin
      grp_any <= grp_any_next;
    end
    if (ctl.sel) begin
      sel   <= sel_next;
      shift <= shift_next;
      found <= |grp_any;
    end
  end

endmodule

// File: sv/buy_sell_order_matcher.sv
// Top level of the buy/sell order matcher: sequencer, cell row and result register.
//
//   Channel  Direction  Handshake                    Beat
//   offer    in         offer_valid / offer_ready    bmo_pkg::offer_t
//   result   out        result_valid / result_ready  bmo_pkg::result_t
//
// Each offer goes through accept, compare in every cell, group OR,
// priority select, then update of the cell row and the result register.
// A new offer is taken while the previous result waits; the update step
// holds until the result register is free. Reset empties the table at once.
module buy_sell_order_matcher (
  input  logic              clk,
  input  logic              rst,
  input  logic              offer_valid,
  output logic              offer_ready,
  input  bmo_pkg::offer_t   offer,
  output logic              result_valid,
  input  logic              result_ready,
  output bmo_pkg::result_t  result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_GRP   = 3'd2;
  localparam logic [2:0] S_SEL   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic [bmo_pkg::CntW-1:0]       count;
  bmo_pkg::offer_t                offer_q;
  logic                           apply_go;
  logic                           full;
  logic [bmo_pkg::TableDepth-1:0] hit;
  logic [bmo_pkg::TableDepth-1:0] sel;
  logic [bmo_pkg::TableDepth-1:0] shift;
  logic                           found;
  logic [bmo_pkg::PriceW-1:0]     paid;
  bmo_pkg::offer_t                entry [bmo_pkg::TableDepth];
  bmo_pkg::prio_ctl_t             prio_ctl;
  bmo_pkg::result_t               result_next;

  assign offer_ready = (state == S_IDLE);
  assign apply_go    = (state == S_APPLY) && (!result_valid || result_ready);
  assign full        = (count == bmo_pkg::CntW'(bmo_pkg::TableDepth));

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (offer_valid) state_next = S_CMP;
      S_CMP:   state_next = S_GRP;
      S_GRP:   state_next = S_SEL;
      S_SEL:   state_next = S_APPLY;
      S_APPLY: if (apply_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Offer holding register.
  always_ff @(posedge clk) begin
    if (offer_valid && offer_ready) begin
      offer_q <= offer;
    end
  end

  // Row of cells; each removal pulls the entry of the next cell down.
  for (genvar i = 0; i < bmo_pkg::TableDepth; i++) begin : g_cell
    bmo_pkg::cell_ctl_t ctl;
    bmo_pkg::offer_t    nbr;

    assign ctl.cmp   = (state == S_CMP);
    assign ctl.shift = apply_go && found && shift[i];
    assign ctl.load  = apply_go && !found && (count == bmo_pkg::CntW'(i));

    if (i < bmo_pkg::TableDepth - 1) begin : g_mid
      assign nbr = entry[i+1];
    end else begin : g_last
      assign nbr = entry[i];
    end

    bmo_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .live  (count > bmo_pkg::CntW'(i)),
      .offer (offer_q),
      .nbr   (nbr),
      .entry (entry[i]),
      .hit   (hit[i])
    );
  end

  // Oldest-match search.
  assign prio_ctl.grp = (state == S_GRP);
  assign prio_ctl.sel = (state == S_SEL);

  bmo_prio u_prio (
    .clk   (clk),
    .ctl   (prio_ctl),
    .hit   (hit),
    .sel   (sel),
    .shift (shift),
    .found (found)
  );

  // Price of the selected entry.
  always_comb begin
    paid = '0;
    for (int i = 0; i < bmo_pkg::TableDepth; i++) begin
      paid = paid | (sel[i] ? entry[i].offer_price : '0);
    end
  end

  // Result of this offer.
  always_comb begin
    if (found) begin
      result_next.outcome     = bmo_pkg::OUTCOME_TRADED;
      result_next.trade_price = (offer_q.offer_side == bmo_pkg::SIDE_FORSALE) ?
                                offer_q.offer_price : paid;
    end else if (full) begin
      result_next.outcome     = bmo_pkg::OUTCOME_DROPPED;
      result_next.trade_price = '0;
    end else begin
      result_next.outcome     = bmo_pkg::OUTCOME_STORED;
      result_next.trade_price = '0;
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_go) begin
      if (found) begin
        count <= count - bmo_pkg::CntW'(1);
      end else if (!full) begin
        count <= count + bmo_pkg::CntW'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (apply_go) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      result <= result_next;
    end
  end

endmodule

// File: sv/bmo_checker.sv
// Port-level checks for the buy/sell order matcher, bound to the top level.
module bmo_checker (
  input logic             clk,
  input logic             rst,
  input logic             offer_valid,
  input logic             offer_ready,
  input bmo_pkg::offer_t  offer,
  input logic             result_valid,
  input logic             result_ready,
  input bmo_pkg::result_t result
);

  // A stalled result beat holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // Only a trade carries a price.
  a_price_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.outcome != bmo_pkg::OUTCOME_TRADED) |->
      (result.trade_price == '0))
    else $error("nonzero price without a trade");

  // The search keeps the offer port closed right after an accept.
  a_busy_first: assert property (@(posedge clk) disable iff (rst)
    offer_valid && offer_ready |=> !offer_ready)
    else $error("offer taken during search");

  // The port is still closed when the update step is reached.
  a_busy_last: assert property (@(posedge clk) disable iff (rst)
    offer_valid && offer_ready |-> ##4 !offer_ready)
    else $error("offer taken before update");

endmodule

bind buy_sell_order_matcher bmo_checker u_bmo_checker (.*);
